// ----- design/acl_pkg.sv -----
// ----------------------------------------------------------------------------
// acl_pkg
// shared types, codes and helpers for the adaptive concurrency limiter
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int LIMIT_W   = 10;
  localparam int LAT_MS_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int CNT_OUT_W = 6;

  localparam int WINDOW_DEPTH_DEF = 50;
  localparam int MIN_SAMPLES_DEF  = 10;

  // register reset values
  localparam logic [LIMIT_W-1:0]  FLOOR_RST = 10'd5;
  localparam logic [LIMIT_W-1:0]  CEIL_RST  = 10'd500;
  localparam logic [LIMIT_W-1:0]  START_RST = 10'd15;
  localparam logic [LAT_MS_W-1:0] HIGH_RST  = 16'd6000;
  localparam logic [LAT_MS_W-1:0] MID_RST   = 16'd3000;
  localparam logic [LAT_MS_W-1:0] LOW_RST   = 16'd1500;

  // floor(v/5) as multiply by ceil(2^18/5) and shift, exact for v < 2^15
  localparam int DIV_IN_W    = 15;
  localparam int DIV_PROD_W  = 31;
  localparam int DIV5_MUL    = 52429;
  localparam int DIV5_SHIFT  = 18;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_ADJUST  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_FEW    = 3'd1,
    ACT_HARD   = 3'd2,
    ACT_EASE   = 3'd3,
    ACT_RAMP   = 3'd4,
    ACT_STEADY = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR = 3'd0,
    CFG_CEIL  = 3'd1,
    CFG_START = 3'd2,
    CFG_HIGH  = 3'd3,
    CFG_MID   = 3'd4,
    CFG_LOW   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    action_e              action;
    logic [LIMIT_W-1:0]   limit;
  } verdict_t;

  function automatic logic [DIV_IN_W-1:0] div5(input logic [DIV_IN_W-1:0] v);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(v) * DIV_PROD_W'(DIV5_MUL);
    return DIV_IN_W'(p >> DIV5_SHIFT);
  endfunction

endpackage

// ----- design/acl_ring.sv -----
// ----------------------------------------------------------------------------
// acl_ring
// sample window store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module acl_ring #(
  parameter int DEPTH  = 50,
  parameter int WIDTH  = 17,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/acl_judge.sv -----
// ----------------------------------------------------------------------------
// acl_judge
// adjust-tick verdict: rate and latency tests, new limit and clamp
// ----------------------------------------------------------------------------
module acl_judge
  import acl_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int MIN_SAMPLES  = MIN_SAMPLES_DEF,
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1),
  parameter int LAT_W        = LAT_MS_W + CNT_W
) (
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [CNT_W-1:0]   errors_i,
  input  logic [LAT_W-1:0]   lat_total_i,
  input  logic [LAT_W-1:0]   high_prod_i,
  input  logic [LAT_W-1:0]   mid_prod_i,
  input  logic [LAT_W-1:0]   low_prod_i,
  input  logic [LIMIT_W-1:0] floor_i,
  input  logic [LIMIT_W-1:0] ceil_i,
  output verdict_t           verdict_o
);

  localparam int EW = CNT_W + 7;

  logic [EW-1:0]        e_x, n_x;
  logic                 err_hard, err_ease, err_ramp;
  logic [DIV_IN_W-1:0]  m3, m17, hard_v, ease_v, step_v;
  logic [LIMIT_W:0]     target, clip;

  always_comb begin
    e_x = EW'(errors_i);
    n_x = EW'(count_i);
    err_hard = (e_x << 2) > n_x;
    err_ease = ((e_x << 3) + (e_x << 1)) > n_x;
    err_ramp = ((e_x << 6) + (e_x << 5) + (e_x << 2)) < ((n_x << 1) + n_x);

    m3     = (DIV_IN_W'(limit_i) << 1) + DIV_IN_W'(limit_i);
    m17    = (DIV_IN_W'(limit_i) << 4) + DIV_IN_W'(limit_i);
    hard_v = div5(m3);
    ease_v = div5(m17 >> 2);
    step_v = div5(m3 >> 2);
    if (step_v < DIV_IN_W'(2)) begin
      step_v = DIV_IN_W'(2);
    end

    verdict_o.action = ACT_STEADY;
    target = {1'b0, limit_i};
    if (count_i < CNT_W'(MIN_SAMPLES)) begin
      verdict_o.action = ACT_FEW;
    end else if (err_hard || lat_total_i > high_prod_i) begin
      verdict_o.action = ACT_HARD;
      target = (LIMIT_W + 1)'(hard_v);
    end else if (err_ease || lat_total_i > mid_prod_i) begin
      verdict_o.action = ACT_EASE;
      target = (LIMIT_W + 1)'(ease_v);
    end else if (err_ramp && lat_total_i < low_prod_i) begin
      verdict_o.action = ACT_RAMP;
      target = {1'b0, limit_i} + (LIMIT_W + 1)'(step_v);
    end

    // floor wins over ceiling when they cross
    clip = (target < {1'b0, ceil_i}) ? target : {1'b0, ceil_i};
    if (clip < {1'b0, floor_i}) begin
      clip = {1'b0, floor_i};
    end

    if (verdict_o.action == ACT_HARD || verdict_o.action == ACT_EASE ||
        verdict_o.action == ACT_RAMP) begin
      verdict_o.limit = clip[LIMIT_W-1:0];
    end else begin
      verdict_o.limit = limit_i;
    end
  end

endmodule

// ----- design/adaptive_concurrency_limiter.sv -----
// ----------------------------------------------------------------------------
// adaptive_concurrency_limiter
// sliding-window concurrency limit controller
// ----------------------------------------------------------------------------
// each request on the input channel is a pushed completion sample (ok bit and
// latency in ms), an adjust tick or a restart; every request yields exactly
// one result: the limit after it, the action taken and the window fill.
// both channels are valid/ready; the config port is a plain write strobe
// with index and data, to be used only while the block is idle; the block
// itself does not enforce this. a result passes the window read stage, then
// the output register. throughput: one request per cycle while the output
// is not stalled; the window store reads the oldest slot in the accept
// cycle and writes the new sample as the request leaves the read stage,
// when the running sums are updated.
// a stalled receiver holds the result in the output register; one more
// request is taken into the read stage, then input ready drops until the
// output drains.
// reset empties the window, loads limit 15 and the default thresholds; the
// window store itself is not cleared; a stored sample is used only once the window is full.
// ----------------------------------------------------------------------------
module adaptive_concurrency_limiter
  import acl_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int MIN_SAMPLES  = MIN_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic                 sample_ok_i,
  input  logic [LAT_MS_W-1:0]  latency_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LIMIT_W-1:0]   current_limit_o,
  output logic [2:0]           action_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int LAT_W  = LAT_MS_W + CNT_W;
  localparam int SMP_W  = LAT_MS_W + 1;

  // configuration registers
  logic [LIMIT_W-1:0]  floor_q, ceil_q, start_q;
  logic [LAT_MS_W-1:0] high_q, mid_q, low_q;

  // front state, advanced at accept
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [CNT_W-1:0]  held_count_q, held_count_d;

  // back state, advanced when the read stage moves on
  logic [CNT_W-1:0]   error_total_q, error_total_d;
  logic [LAT_W-1:0]   latency_total_q, latency_total_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;

  // read stage
  logic                s1_valid_q;
  logic [1:0]          s1_op_q;
  logic                s1_ok_q;
  logic [LAT_MS_W-1:0] s1_lat_q;
  logic [SLOT_W-1:0]   s1_slot_q;
  logic                s1_full_q;
  logic [CNT_W-1:0]    s1_count_q;
  logic [LAT_W-1:0]    s1_high_q, s1_mid_q, s1_low_q;

  // output register
  logic                 out_valid_q;
  logic [LIMIT_W-1:0]   out_limit_q;
  logic [2:0]           out_action_q;
  logic [CNT_OUT_W-1:0] out_count_q;

  logic               in_acc, s1_adv;
  logic               ring_we;
  logic [SMP_W-1:0]   old_smp;
  logic               old_ok;
  logic [LAT_MS_W-1:0] old_lat;
  logic [LAT_W-1:0]   lat_sub;
  logic               err_sub;
  verdict_t           verdict;
  action_e            res_action;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RST;
      ceil_q  <= CEIL_RST;
      start_q <= START_RST;
      high_q  <= HIGH_RST;
      mid_q   <= MID_RST;
      low_q   <= LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLOOR: floor_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_CEIL:  ceil_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_START: start_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_HIGH:  high_q  <= cfg_data_i;
        CFG_MID:   mid_q   <= cfg_data_i;
        CFG_LOW:   low_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot and fill advance at accept; they never wait on stored data
  always_comb begin
    write_slot_d = write_slot_q;
    held_count_d = held_count_q;
    if (in_acc) begin
      if (opcode_i == OP_PUSH) begin
        if (held_count_q < CNT_W'(WINDOW_DEPTH)) begin
          held_count_d = held_count_q + CNT_W'(1);
        end
        if (write_slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
          write_slot_d = '0;
        end else begin
          write_slot_d = write_slot_q + SLOT_W'(1);
        end
      end else if (opcode_i == OP_RESTART) begin
        write_slot_d = '0;
        held_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      held_count_q <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      write_slot_q <= write_slot_d;
      held_count_q <= held_count_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // read stage payload; threshold products taken against the current fill
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= opcode_i;
      s1_ok_q    <= sample_ok_i;
      s1_lat_q   <= latency_ms_i;
      s1_slot_q  <= write_slot_q;
      s1_full_q  <= held_count_q >= CNT_W'(WINDOW_DEPTH);
      s1_count_q <= held_count_d;
      s1_high_q  <= LAT_W'(high_q) * LAT_W'(held_count_q);
      s1_mid_q   <= LAT_W'(mid_q) * LAT_W'(held_count_q);
      s1_low_q   <= LAT_W'(low_q) * LAT_W'(held_count_q);
    end
  end

  // oldest slot read at accept, new sample written as the request moves on;
  // consecutive pushes touch neighbouring slots so the two never meet
  assign ring_we = s1_adv && (s1_op_q == OP_PUSH);

  acl_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .WIDTH  (SMP_W),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .re_i    (in_acc),
    .raddr_i (write_slot_q),
    .rdata_o (old_smp),
    .we_i    (ring_we),
    .waddr_i (s1_slot_q),
    .wdata_i ({s1_ok_q, s1_lat_q})
  );

  acl_judge #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_SAMPLES  (MIN_SAMPLES),
    .CNT_W        (CNT_W),
    .LAT_W        (LAT_W)
  ) u_judge (
    .limit_i     (limit_q),
    .count_i     (s1_count_q),
    .errors_i    (error_total_q),
    .lat_total_i (latency_total_q),
    .high_prod_i (s1_high_q),
    .mid_prod_i  (s1_mid_q),
    .low_prod_i  (s1_low_q),
    .floor_i     (floor_q),
    .ceil_i      (ceil_q),
    .verdict_o   (verdict)
  );

  // running sums and limit
  always_comb begin
    old_ok  = old_smp[SMP_W-1];
    old_lat = old_smp[LAT_MS_W-1:0];
    err_sub = s1_full_q && !old_ok && (error_total_q != '0);
    lat_sub = '0;
    if (s1_full_q) begin
      lat_sub = (LAT_W'(old_lat) <= latency_total_q) ? LAT_W'(old_lat) : latency_total_q;
    end

    error_total_d   = error_total_q;
    latency_total_d = latency_total_q;
    limit_d         = limit_q;
    res_action      = ACT_NONE;
    if (s1_adv) begin
      case (s1_op_q)
        OP_PUSH: begin
          error_total_d   = error_total_q - CNT_W'(err_sub) + CNT_W'(!s1_ok_q);
          latency_total_d = latency_total_q - lat_sub + LAT_W'(s1_lat_q);
        end
        OP_ADJUST: begin
          limit_d    = verdict.limit;
          res_action = verdict.action;
        end
        OP_RESTART: begin
          limit_d         = start_q;
          error_total_d   = '0;
          latency_total_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_total_q   <= '0;
      latency_total_q <= '0;
      limit_q         <= START_RST;
      out_valid_q     <= 1'b0;
    end else begin
      error_total_q   <= error_total_d;
      latency_total_q <= latency_total_d;
      limit_q         <= limit_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_limit_q  <= limit_d;
      out_action_q <= res_action;
      out_count_q  <= CNT_OUT_W'(s1_count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_limit_o = out_limit_q;
  assign action_o        = out_action_q;
  assign sample_count_o  = out_count_q;

  // window store never sees a read and a write of the same slot together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ring_we) |-> (write_slot_q != s1_slot_q))
    else $error("window read and write hit the same slot");

  // fill never exceeds the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  // while filling, the write slot tracks the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q < CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(write_slot_q) == held_count_q))
    else $error("write slot out of step with fill");

  // too-few-samples only reported below the minimum fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_action_q == ACT_FEW) |->
      (out_count_q < CNT_OUT_W'(MIN_SAMPLES)))
    else $error("too-few action with enough samples");

endmodule

// ----- tb/tb_adaptive_concurrency_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_concurrency_limiter
// self-checking bench for the sliding-window concurrency limit controller
// ----------------------------------------------------------------------------
// a short directed run under reset settings walks through every action, then
// eight phases with fresh register settings send random requests, mostly
// well-formed completion samples with occasional ticks and restarts. a
// scoreboard keeps its own window and totals, predicts each result and
// checks the results in order. both channels idle at random and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
import acl_pkg::*;

typedef struct packed {
  logic [LIMIT_W-1:0]   limit;
  action_e              action;
  logic [CNT_OUT_W-1:0] count;
} limiter_result_t;

class limiter_scoreboard;
  logic [LIMIT_W-1:0]  floor_reg, ceil_reg, start_reg;
  logic [LAT_MS_W-1:0] high_reg, mid_reg, low_reg;
  logic [16:0]         ring [WINDOW_DEPTH_DEF];
  int unsigned         slot, held, fails, lat_sum;
  logic [LIMIT_W-1:0]  limit_now;
  limiter_result_t     expected_q[$];
  int unsigned         errors;

  function new();
    floor_reg = FLOOR_RST;
    ceil_reg  = CEIL_RST;
    start_reg = START_RST;
    high_reg  = HIGH_RST;
    mid_reg   = MID_RST;
    low_reg   = LOW_RST;
    limit_now = START_RST;
    slot      = 0;
    held      = 0;
    fails     = 0;
    lat_sum   = 0;
    errors    = 0;
    foreach (ring[i]) ring[i] = '0;
  endfunction

  function void set_register(cfg_idx_e idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_FLOOR: floor_reg = val[LIMIT_W-1:0];
      CFG_CEIL:  ceil_reg  = val[LIMIT_W-1:0];
      CFG_START: start_reg = val[LIMIT_W-1:0];
      CFG_HIGH:  high_reg  = val;
      CFG_MID:   mid_reg   = val;
      CFG_LOW:   low_reg   = val;
      default: ;
    endcase
  endfunction

  // floor wins when it sits above the ceiling
  function logic [LIMIT_W-1:0] clamp(longint unsigned x);
    longint unsigned v;
    v = (x < ceil_reg) ? x : longint'(ceil_reg);
    if (v < floor_reg) v = floor_reg;
    return LIMIT_W'(v);
  endfunction

  function action_e judge();
    longint unsigned n, e, s, lim, step;
    n   = held;
    e   = fails;
    s   = lat_sum;
    lim = limit_now;
    if (n < MIN_SAMPLES_DEF) return ACT_FEW;
    if (4 * e > n || s > high_reg * n) begin
      limit_now = clamp(lim * 3 / 5);
      return ACT_HARD;
    end
    if (10 * e > n || s > mid_reg * n) begin
      limit_now = clamp(lim * 17 / 20);
      return ACT_EASE;
    end
    if (100 * e < 3 * n && s < low_reg * n) begin
      step = lim * 3 / 20;
      if (step < 2) step = 2;
      limit_now = clamp(lim + step);
      return ACT_RAMP;
    end
    return ACT_STEADY;
  endfunction

  function void note_request(logic [1:0] op, logic ok, logic [LAT_MS_W-1:0] lat);
    limiter_result_t r;
    logic [16:0]     old;
    r.action = ACT_NONE;
    case (op)
      OP_PUSH: begin
        // full window: retire the oldest sample before overwriting its slot
        if (held >= WINDOW_DEPTH_DEF) begin
          old = ring[slot];
          if (!old[16] && fails > 0) fails--;
          lat_sum -= (old[15:0] <= lat_sum) ? int'(old[15:0]) : lat_sum;
        end else begin
          held++;
        end
        ring[slot] = {ok, lat};
        if (!ok) fails++;
        lat_sum += lat;
        slot = (slot + 1 >= WINDOW_DEPTH_DEF) ? 0 : slot + 1;
      end
      OP_ADJUST: r.action = judge();
      OP_RESTART: begin
        limit_now = start_reg;
        slot      = 0;
        held      = 0;
        fails     = 0;
        lat_sum   = 0;
      end
      default: ;
    endcase
    r.limit = limit_now;
    r.count = CNT_OUT_W'(held);
    expected_q.push_back(r);
  endfunction

  function void report(string field, int unsigned want, int unsigned got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_result(logic [LIMIT_W-1:0] limit, logic [2:0] action,
                             logic [CNT_OUT_W-1:0] count);
    limiter_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, limit %0d action %0d count %0d",
               $time, limit, action, count);
      return;
    end
    want = expected_q[0];
    expected_q.delete(0);
    if (limit !== want.limit)   report("current_limit", want.limit, limit);
    if (action !== want.action) report("action", want.action, action);
    if (count !== want.count)   report("sample_count", want.count, count);
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_adaptive_concurrency_limiter;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  // the one opcode the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           opcode_i;
  logic                 sample_ok_i;
  logic [LAT_MS_W-1:0]  latency_ms_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LIMIT_W-1:0]   current_limit_o;
  logic [2:0]           action_o;
  logic [CNT_OUT_W-1:0] sample_count_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  limiter_scoreboard sb = new();

  // burst flags switch idling off for stretches on either side
  bit          tx_burst;
  bit          rx_burst;
  // raised by the stimulus, served and cleared by the receiver
  bit          hold_off_req;
  int unsigned idle_cycles;

  adaptive_concurrency_limiter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sample_ok_i     (sample_ok_i),
    .latency_ms_i    (latency_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .current_limit_o (current_limit_o),
    .action_o        (action_o),
    .sample_count_o  (sample_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // offer one request after a random gap and wait for it to be taken;
  // valid stays high on return so a back-to-back request needs no toggle
  task automatic send_item(input logic [1:0] op, input logic ok,
                           input logic [LAT_MS_W-1:0] lat);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    sample_ok_i  <= ok;
    latency_ms_i <= lat;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, ok, lat);
  endtask

  // stop offering and let every outstanding result drain out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register per cycle, strobe held across the whole burst of writes
  task automatic put_register(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_register(idx, val);
  endtask

  task automatic load_settings(input logic [LIMIT_W-1:0] fl, input logic [LIMIT_W-1:0] ce,
                               input logic [LIMIT_W-1:0] st, input logic [LAT_MS_W-1:0] hi,
                               input logic [LAT_MS_W-1:0] mi, input logic [LAT_MS_W-1:0] lo);
    put_register(CFG_FLOOR, CFG_W'(fl));
    put_register(CFG_CEIL,  CFG_W'(ce));
    put_register(CFG_START, CFG_W'(st));
    put_register(CFG_HIGH,  hi);
    put_register(CFG_MID,   mi);
    put_register(CFG_LOW,   lo);
    cfg_we_i <= 1'b0;
  endtask

  // result monitor: outputs are sampled at the edge where the handshake lands
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(current_limit_o, action_o, sample_count_o);
  end

  // watchdog: too long without a handshake on either channel ends the run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall before each result, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0]  fl, ce, st;
    logic [LAT_MS_W-1:0] hi, mi, lo;
    int unsigned         err_pct, lat_span, counted, pick;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    opcode_i     <= OP_PUSH;
    sample_ok_i  <= 1'b0;
    latency_ms_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_FLOOR;
    cfg_data_i   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed part, reset settings ----
    // tick on an empty window, then the unused opcode
    send_item(OP_ADJUST, 1'b1, 16'hFFFF);
    send_item(OP_UNUSED, 1'b0, 16'hFFFF);
    // ten quick successes reach the sample minimum and allow a ramp
    for (int i = 0; i < 10; i++) send_item(OP_PUSH, 1'b1, LAT_MS_W'(i * 100));
    send_item(OP_ADJUST, 1'b0, 16'h0000);
    // one failure in eleven: neither ramp nor back-off
    send_item(OP_PUSH, 1'b0, 16'h0000);
    send_item(OP_ADJUST, 1'b1, 16'h0000);
    // a slow failure pushes the error rate and mean latency up: ease off
    send_item(OP_PUSH, 1'b0, 16'hFFFF);
    send_item(OP_ADJUST, 1'b0, 16'hFFFF);
    // more failures: hard back-off
    send_item(OP_PUSH, 1'b0, 16'h0000);
    send_item(OP_PUSH, 1'b0, 16'h5555);
    send_item(OP_PUSH, 1'b1, 16'hAAAA);
    send_item(OP_ADJUST, 1'b1, 16'h0000);
    // restart empties the window, so the next tick sees too few samples
    send_item(OP_RESTART, 1'b1, 16'hFFFF);
    send_item(OP_ADJUST, 1'b0, 16'h0000);
    send_item(OP_PUSH, 1'b1, 16'hFFFF);
    wait_idle();

    // ---- random phases, fresh settings each time ----
    for (int phase = 0; phase < PHASES; phase++) begin
      lo = LAT_MS_W'($urandom_range(50, 3000));
      mi = lo + LAT_MS_W'($urandom_range(0, 3000));
      hi = mi + LAT_MS_W'($urandom_range(0, 6000));
      fl = LIMIT_W'($urandom_range(1, 40));
      ce = LIMIT_W'($urandom_range(100, 1023));
      st = LIMIT_W'($urandom_range(1, 1023));
      case (phase)
        0: begin
          // widest clamp range, start at the top
          fl = 10'd1;
          ce = 10'd1023;
          st = 10'd1023;
        end
        1: begin
          // floor above ceiling
          fl = 10'd1023;
          ce = 10'd1;
          st = 10'd1;
        end
        2: st = 10'd0;  // restart loads zero as written
        3: begin
          fl = 10'd1;
          ce = 10'd1023;
          hi = 16'hFFFF;
          mi = 16'hFFFF;
          lo = 16'hFFFF;
        end
        4: begin
          hi = '0;
          mi = '0;
          lo = '0;
        end
        default: begin
          fl = LIMIT_W'($urandom_range(1, 1023));
          ce = LIMIT_W'($urandom_range(1, 1023));
          if ($urandom_range(0, 1) == 0) begin
            hi = LAT_MS_W'($urandom_range(0, 65535));
            mi = LAT_MS_W'($urandom_range(0, 65535));
            lo = LAT_MS_W'($urandom_range(0, 65535));
          end
        end
      endcase
      load_settings(fl, ce, st, hi, mi, lo);
      // let the output back up while the sender keeps offering
      if (phase == 5) hold_off_req = 1'b1;

      send_item(OP_RESTART, 1'($urandom_range(0, 1)), LAT_MS_W'($urandom_range(0, 65535)));
      counted = 1;
      while (counted < PHASE_ITEMS) begin
        // new error rate and latency spread every few dozen requests
        if (counted % 40 == 1) begin
          case ($urandom_range(0, 5))
            0: err_pct = 0;
            1: err_pct = 1;
            2: err_pct = 3;
            3: err_pct = 8;
            4: err_pct = 20;
            default: err_pct = 50;
          endcase
          case ($urandom_range(0, 3))
            0: lat_span = 2 * lo;
            1: lat_span = 2 * mi;
            2: lat_span = 2 * hi;
            default: lat_span = 65535;
          endcase
          if (lat_span > 65535) lat_span = 65535;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_item(OP_UNUSED, 1'($urandom_range(0, 1)),
                    LAT_MS_W'($urandom_range(0, 65535)));
        end else begin
          if (pick < 3)
            send_item(OP_RESTART, 1'($urandom_range(0, 1)),
                      LAT_MS_W'($urandom_range(0, 65535)));
          else if (pick < 13)
            send_item(OP_ADJUST, 1'($urandom_range(0, 1)),
                      LAT_MS_W'($urandom_range(0, 65535)));
          else if (pick < 18)
            send_item(OP_PUSH, 1'($urandom_range(0, 1)),
                      LAT_MS_W'($urandom_range(0, 65535)));
          else
            send_item(OP_PUSH, $urandom_range(0, 99) >= err_pct,
                      LAT_MS_W'($urandom_range(0, lat_span)));
          counted++;
        end
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
